// File: hw/rtl/mte_pkg.sv
// types, constants and symbol tables shared by the multi-tap text entry block
`default_nettype none

package mte_pkg;

   localparam int SymbolsPerKey = 4;
   localparam int SpecialCount  = 10;
   localparam int TableCols     = 4;

   localparam logic [4:0] NoKey = 5'd31;

   typedef enum logic [1:0] {
      EVT_NONE    = 2'd0,
      EVT_PREVIEW = 2'd1,
      EVT_CLEAR   = 2'd2,
      EVT_END     = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      REG_TIMEOUT = 2'd0,
      REG_CAPS    = 2'd1,
      REG_CLEAR   = 2'd2,
      REG_SPECIAL = 2'd3
   } reg_index_type;

   localparam logic ActionPress = 1'b0;
   localparam logic ActionTick  = 1'b1;

   typedef struct packed {
      logic        active;
      logic [3:0]  tap;
      logic [4:0]  prev_key;
      logic [7:0]  cur_sym;
      logic        sym_valid;
      logic [15:0] idle;
      logic        caps;
      logic        special;
   } state_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [3:0]  caps_key;
      logic [3:0]  clear_key;
      logic [3:0]  special_key;
   } config_type;

   typedef struct packed {
      event_type  kind;
      logic [7:0] symbol;
      logic       has_symbol;
   } result_type;

   // one keypad row, first column in the top byte
   function automatic logic [31:0] key_row(input logic [3:0] key);
      logic [31:0] row;
      case (key)
         4'd0:    row = {" ", "0", "0", "0"};
         4'd1:    row = {"a", "b", "c", "1"};
         4'd2:    row = {"d", "e", "f", "2"};
         4'd3:    row = {"g", "h", "i", "3"};
         4'd4:    row = {"j", "k", "l", "4"};
         4'd5:    row = {"m", "n", "o", "5"};
         4'd6:    row = {"p", "q", "r", "6"};
         4'd7:    row = {"s", "t", "u", "7"};
         4'd8:    row = {"v", "w", "x", "8"};
         4'd9:    row = {"y", "z", ".", "9"};
         default: row = {"0", "0", "0", "0"};
      endcase
      return row;
   endfunction

   function automatic logic [7:0] key_symbol(input logic [3:0] key, input logic [1:0] col,
                                             input logic caps);
      logic [31:0] row;
      logic [7:0]  c;
      row = key_row(key);
      c   = row[8 * (TableCols - 1 - int'(col)) +: 8];
      if (caps && c >= "a" && c <= "z") begin
         c = c - 8'd32;
      end
      return c;
   endfunction

   function automatic logic [7:0] punct_symbol(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "!";
         4'd1:    c = "@";
         4'd2:    c = "#";
         4'd3:    c = "$";
         4'd4:    c = "%";
         4'd5:    c = "^";
         4'd6:    c = "&";
         4'd7:    c = "*";
         4'd8:    c = "-";
         default: c = "_";
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/multi_tap_text_entry.sv
// top level of the multi-tap keypad text entry block
`default_nettype none

// Multi-tap keypad text entry. Each transfer on the req_ stream is a key press
// (tuser 0, key code in tdata[3:0]) or one timer tick (tuser 1), and gives
// exactly one transfer on the rsp_ stream: a preview symbol, a clear-screen
// request, a session end carrying the last symbol, or nothing. An item is held
// in the input register and is resolved in one pass through the table lookup and
// tap-count logic into the result register, so the block takes one item
// per clock while the response side keeps up. Timeout and function keys are set
// through the csr_ port: 0x0 timeout ticks, 0x4 caps key, 0x8 clear key, 0xC
// special key.

module multi_tap_text_entry (
   input  wire        clock,
   input  wire        reset,
   // request stream
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // [3:0] key_code, [7:4] zero
   input  wire        req_tuser,   // [0] action
   // response stream
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] symbol
   output logic [2:0] rsp_tuser,   // [1:0] event_kind, [2] has_symbol
   // configuration
   input  wire        csr_psel,
   input  wire        csr_penable,
   input  wire        csr_pwrite,
   input  wire [3:0]  csr_paddr,
   input  wire [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic       csr_pready
);

   mte_pkg::state_type  state_ff;
   mte_pkg::state_type  state_in;
   mte_pkg::config_type cfg_ff;
   mte_pkg::result_type result_in;
   mte_pkg::result_type result_ff;

   logic       in_valid_ff;
   logic       in_action_ff;
   logic [3:0] in_key_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       cfg_write;
   mte_pkg::reg_index_type reg_sel;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = mte_pkg::reg_index_type'(csr_paddr[3:2]);

   mte_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .action    (in_action_ff),
      .key_code  (in_key_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tuser;
         in_key_ff    <= req_tdata[3:0];
      end
   end

   // session state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{active: 1'b0, tap: 4'd0, prev_key: mte_pkg::NoKey, cur_sym: 8'd0,
                       sym_valid: 1'b0, idle: 16'd0, caps: 1'b0, special: 1'b0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff.symbol;
   assign rsp_tuser  = {result_ff.has_symbol, result_ff.kind};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{timeout_ticks: 16'd100, caps_key: 4'd12, clear_key: 4'd10,
                     special_key: 4'd11};
      end else if (cfg_write) begin
         unique case (reg_sel)
            mte_pkg::REG_TIMEOUT: cfg_ff.timeout_ticks <= csr_pwdata[15:0];
            mte_pkg::REG_CAPS:    cfg_ff.caps_key      <= csr_pwdata[3:0];
            mte_pkg::REG_CLEAR:   cfg_ff.clear_key     <= csr_pwdata[3:0];
            mte_pkg::REG_SPECIAL: cfg_ff.special_key   <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         mte_pkg::REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         mte_pkg::REG_CAPS:    csr_prdata = {28'd0, cfg_ff.caps_key};
         mte_pkg::REG_CLEAR:   csr_prdata = {28'd0, cfg_ff.clear_key};
         mte_pkg::REG_SPECIAL: csr_prdata = {28'd0, cfg_ff.special_key};
         default:              csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/mte_step.sv
// next-state and result logic for one key press or timer tick
`default_nettype none

module mte_step (
   input  wire mte_pkg::state_type  state_cur,
   input  wire mte_pkg::config_type cfg,
   input  wire                      action,
   input  wire [3:0]                key_code,
   output mte_pkg::state_type       state_nxt,
   output mte_pkg::result_type      result
);

   logic [15:0]        idle_inc;
   mte_pkg::state_type work;
   logic               is_caps;
   logic               is_clear;
   logic               is_special;
   logic [1:0]         col;
   logic [3:0]         pidx;
   logic [7:0]         sym;

   assign idle_inc   = (state_cur.idle != 16'hFFFF) ? state_cur.idle + 16'd1 : state_cur.idle;
   assign is_caps    = (key_code == cfg.caps_key);
   assign is_clear   = (key_code == cfg.clear_key);
   assign is_special = (key_code == cfg.special_key);

   always_comb begin
      work       = state_cur;
      state_nxt  = state_cur;
      result     = '{kind: mte_pkg::EVT_NONE, symbol: 8'd0, has_symbol: 1'b0};
      col        = 2'd0;
      pidx       = 4'd0;
      sym        = 8'd0;

      if (action == mte_pkg::ActionTick) begin
         if (state_cur.active) begin
            if (idle_inc >= cfg.timeout_ticks) begin
               result.kind       = mte_pkg::EVT_END;
               result.has_symbol = state_cur.sym_valid;
               result.symbol     = state_cur.sym_valid ? state_cur.cur_sym : 8'd0;
               state_nxt.active    = 1'b0;
               state_nxt.tap       = 4'd0;
               state_nxt.prev_key  = mte_pkg::NoKey;
               state_nxt.idle      = 16'd0;
               state_nxt.sym_valid = 1'b0;
            end else begin
               state_nxt.idle = idle_inc;
            end
         end
      end else begin
         // open a session or work out where the tap count restarts
         if (!state_cur.active) begin
            work.active    = 1'b1;
            work.tap       = 4'd0;
            work.prev_key  = mte_pkg::NoKey;
            work.sym_valid = 1'b0;
            work.idle      = 16'd0;
         end else if (state_cur.special) begin
            if (state_cur.tap >= 4'(mte_pkg::SpecialCount)) begin
               work.tap = 4'd0;
            end
         end else if ({1'b0, key_code} != state_cur.prev_key
                      || state_cur.tap >= 4'(mte_pkg::SymbolsPerKey)
                      || state_cur.tap == 4'(mte_pkg::SpecialCount)) begin
            work.tap = 4'd0;
         end

         if (is_caps || is_clear || is_special) begin
            result.kind       = (!is_caps && is_clear) ? mte_pkg::EVT_CLEAR : mte_pkg::EVT_END;
            result.has_symbol = work.sym_valid;
            result.symbol     = work.sym_valid ? work.cur_sym : 8'd0;
            state_nxt           = work;
            state_nxt.active    = 1'b0;
            state_nxt.tap       = 4'd0;
            state_nxt.prev_key  = mte_pkg::NoKey;
            state_nxt.idle      = 16'd0;
            state_nxt.sym_valid = 1'b0;
            if (is_caps) begin
               state_nxt.caps    = ~state_cur.caps;
               state_nxt.special = 1'b0;
            end else if (!is_clear) begin
               state_nxt.special = ~state_cur.special;
            end
         end else begin
            state_nxt = work;
            if (state_cur.special) begin
               if (key_code == 4'd1) begin
                  pidx = (work.tap < 4'(mte_pkg::SpecialCount))
                         ? work.tap : 4'(mte_pkg::SpecialCount - 1);
                  sym  = mte_pkg::punct_symbol(pidx);
                  state_nxt.cur_sym   = sym;
                  state_nxt.sym_valid = 1'b1;
                  result = '{kind: mte_pkg::EVT_PREVIEW, symbol: sym, has_symbol: 1'b1};
               end
            end else begin
               col = (work.tap < 4'(mte_pkg::TableCols))
                     ? work.tap[1:0] : 2'(mte_pkg::TableCols - 1);
               sym = mte_pkg::key_symbol(key_code, col, state_cur.caps);
               state_nxt.cur_sym   = sym;
               state_nxt.sym_valid = 1'b1;
               result = '{kind: mte_pkg::EVT_PREVIEW, symbol: sym, has_symbol: 1'b1};
            end
            state_nxt.idle     = 16'd0;
            state_nxt.prev_key = {1'b0, key_code};
            state_nxt.tap      = work.tap + 4'd1;
         end
      end
   end

endmodule

`default_nettype wire

// File: bench/multi_tap_text_entry_test.sv
// self-checking testbench for the multi-tap text entry block, with its own event predictor
`default_nettype none

module multi_tap_text_entry_test;

   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 310;

   class entry_checker;
      int                  errors;
      mte_pkg::result_type expected_events[$];
      logic [15:0]         timeout_ticks;
      logic [3:0]          caps_key;
      logic [3:0]          clear_key;
      logic [3:0]          special_key;
      logic                active;
      logic                sym_valid;
      logic                caps;
      logic                special;
      logic [3:0]          tap;
      logic [4:0]          prev_key;
      logic [7:0]          cur_sym;
      logic [15:0]         idle;
      string               keypad = " 000abc1def2ghi3jkl4mno5pqr6stu7vwx8yz.9";
      string               punct  = "!@#$%^&*-_";

      function new();
         errors        = 0;
         timeout_ticks = 16'd100;
         caps_key      = 4'd12;
         clear_key     = 4'd10;
         special_key   = 4'd11;
         active        = 1'b0;
         sym_valid     = 1'b0;
         caps          = 1'b0;
         special       = 1'b0;
         tap           = 4'd0;
         prev_key      = mte_pkg::NoKey;
         cur_sym       = 8'h00;
         idle          = 16'd0;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      function void write_reg(mte_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            mte_pkg::REG_TIMEOUT: timeout_ticks = value[15:0];
            mte_pkg::REG_CAPS:    caps_key      = value[3:0];
            mte_pkg::REG_CLEAR:   clear_key     = value[3:0];
            mte_pkg::REG_SPECIAL: special_key   = value[3:0];
            default: ;
         endcase
      endfunction

      function mte_pkg::result_type close_session(mte_pkg::event_type kind);
         mte_pkg::result_type r;
         logic                shown;
         shown        = active & sym_valid;
         r.kind       = kind;
         r.symbol     = shown ? cur_sym : 8'h00;
         r.has_symbol = shown;
         active       = 1'b0;
         tap          = 4'd0;
         prev_key     = mte_pkg::NoKey;
         idle         = 16'd0;
         sym_valid    = 1'b0;
         return r;
      endfunction

      function void note_item(logic action, logic [3:0] key);
         mte_pkg::result_type r;
         logic [7:0]          sym;
         int                  col;
         r.kind       = mte_pkg::EVT_NONE;
         r.symbol     = 8'h00;
         r.has_symbol = 1'b0;
         if (action == mte_pkg::ActionTick) begin
            if (active) begin
               if (idle != 16'hFFFF) idle = idle + 16'd1;
               if (idle >= timeout_ticks) r = close_session(mte_pkg::EVT_END);
            end
         end else begin
            if (!active) begin
               active    = 1'b1;
               tap       = 4'd0;
               prev_key  = mte_pkg::NoKey;
               sym_valid = 1'b0;
               idle      = 16'd0;
            end else if (special) begin
               if (tap >= mte_pkg::SpecialCount) tap = 4'd0;
            end else if ({1'b0, key} != prev_key || tap >= mte_pkg::SymbolsPerKey) begin
               tap = 4'd0;
            end
            if (key == caps_key) begin
               caps    = ~caps;
               special = 1'b0;
               r       = close_session(mte_pkg::EVT_END);
            end else if (key == clear_key) begin
               r = close_session(mte_pkg::EVT_CLEAR);
            end else if (key == special_key) begin
               special = ~special;
               r       = close_session(mte_pkg::EVT_END);
            end else begin
               if (special) begin
                  if (key == 4'd1) begin
                     col = (tap < mte_pkg::SpecialCount) ? int'(tap)
                                                         : mte_pkg::SpecialCount - 1;
                     sym = punct[col];
                     cur_sym      = sym;
                     sym_valid    = 1'b1;
                     r.kind       = mte_pkg::EVT_PREVIEW;
                     r.symbol     = sym;
                     r.has_symbol = 1'b1;
                  end
               end else begin
                  col = (tap < mte_pkg::TableCols) ? int'(tap) : mte_pkg::TableCols - 1;
                  sym = (key > 4'd9) ? "0" : keypad[int'(key) * mte_pkg::TableCols + col];
                  if (caps && sym >= "a" && sym <= "z") sym = sym - 8'd32;
                  cur_sym      = sym;
                  sym_valid    = 1'b1;
                  r.kind       = mte_pkg::EVT_PREVIEW;
                  r.symbol     = sym;
                  r.has_symbol = 1'b1;
               end
               idle     = 16'd0;
               prev_key = {1'b0, key};
               tap      = tap + 4'd1;
            end
         end
         expected_events.push_back(r);
      endfunction

      task check_event(logic [1:0] kind, logic [7:0] sym, logic has);
         mte_pkg::result_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("unexpected transfer: kind %0d symbol %h has %0d", kind, sym, has));
            return;
         end
         want = expected_events.pop_front();
         if (kind !== want.kind)
            report($sformatf("event kind %0d, expected %0d", kind, want.kind));
         if (sym !== want.symbol)
            report($sformatf("symbol %h, expected %h", sym, want.symbol));
         if (has !== want.has_symbol)
            report($sformatf("has_symbol %0d, expected %0d", has, want.has_symbol));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [3:0] key_code, [7:4] zero
   logic        req_tuser = 1'b0;    // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] symbol
   logic [2:0]  rsp_tuser;           // [1:0] event_kind, [2] has_symbol
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   entry_checker board = new();
   int cycles = 0;
   int items_sent = 0;
   int send_gap_pct = 10;
   int recv_stall_pct = 48;

   multi_tap_text_entry u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_event(rsp_tuser[1:0], rsp_tdata, rsp_tuser[2]);
   end

   task automatic push_item(logic action, logic [3:0] key);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0000, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(action, key);
      items_sent++;
   endtask

   task automatic press_run(logic [3:0] key, int count);
      repeat (count) push_item(mte_pkg::ActionPress, key);
   endtask

   task automatic tick_run(int count);
      repeat (count) push_item(mte_pkg::ActionTick, 4'($urandom_range(15)));
   endtask

   // hold the sender until every outstanding transfer has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(mte_pkg::reg_index_type idx, logic [31:0] value);
      logic [31:0] want;
      want = (idx == mte_pkg::REG_TIMEOUT) ? {16'h0, value[15:0]} : {28'h0, value[3:0]};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want)
         board.report($sformatf("register %0d reads %h, expected %h", idx, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(logic [15:0] timeout, logic [3:0] caps_k, logic [3:0] clear_k,
                            logic [3:0] special_k);
      drain();
      csr_write(mte_pkg::REG_TIMEOUT, {16'h0, timeout});
      csr_write(mte_pkg::REG_CAPS, {28'h0, caps_k});
      csr_write(mte_pkg::REG_CLEAR, {28'h0, clear_k});
      csr_write(mte_pkg::REG_SPECIAL, {28'h0, special_k});
   endtask

   task automatic random_phase(int count);
      int         stop;
      int         pick;
      int         burst;
      logic [3:0] key;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            key = ($urandom_range(9) < 8) ? 4'($urandom_range(9)) : 4'($urandom_range(15));
            press_run(key, $urandom_range(6, 1));
         end else if (pick < 65) begin
            burst = int'(board.timeout_ticks) + 1;
            if (burst > 12) burst = 12;
            tick_run($urandom_range(burst, 1));
         end else if (pick < 75) begin
            case ($urandom_range(2))
               0:       push_item(mte_pkg::ActionPress, board.caps_key);
               1:       push_item(mte_pkg::ActionPress, board.clear_key);
               default: push_item(mte_pkg::ActionPress, board.special_key);
            endcase
         end else if (pick < 87) begin
            press_run(4'd1, $urandom_range(12, 1));
         end else if (pick < 99) begin
            push_item(1'($urandom_range(1)), 4'($urandom_range(15)));
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, column wrap, keys above nine, caps, clear, special mode, timeout
      configure(16'd2, 4'd12, 4'd10, 4'd11);
      push_item(mte_pkg::ActionTick, 4'd0);
      press_run(4'd0, 5);
      press_run(4'd9, 4);
      push_item(mte_pkg::ActionPress, 4'd15);
      push_item(mte_pkg::ActionPress, 4'd12);
      push_item(mte_pkg::ActionPress, 4'd1);
      push_item(mte_pkg::ActionPress, 4'd10);
      push_item(mte_pkg::ActionPress, 4'd10);
      push_item(mte_pkg::ActionPress, 4'd11);
      push_item(mte_pkg::ActionPress, 4'd5);
      press_run(4'd1, 3);
      tick_run(2);
      push_item(mte_pkg::ActionPress, 4'd11);
      push_item(mte_pkg::ActionPress, 4'd12);
      push_item(mte_pkg::ActionPress, 4'd4);

      configure(16'd1, 4'd0, 4'd15, 4'd9);
      random_phase(PhaseItems);
      configure(16'hFFFF, 4'd15, 4'd0, 4'd1);
      random_phase(PhaseItems);

      send_gap_pct   = 48;
      recv_stall_pct = 10;
      configure(16'd0, 4'd5, 4'd5, 4'd5);
      random_phase(PhaseItems);
      configure(16'd5, 4'd12, 4'd10, 4'd11);
      random_phase(PhaseItems);

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      configure(16'd3, 4'd13, 4'd14, 4'd15);
      random_phase(PhaseItems);
      configure(16'd100, 4'd7, 4'd3, 4'd2);
      random_phase(PhaseItems);

      drain();
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
